// ----- hw/rtl/sms_pkg.sv -----
// Shared types and constants for the SPI master shift engine.
package sms_pkg;

  localparam int unsigned WordW = 9;
  localparam int unsigned CntW  = 8;
  localparam int unsigned BitsW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [BitsW-1:0] CharBitsLong  = 4'd9;
  localparam logic [BitsW-1:0] CharBitsShort = 4'd8;
  localparam logic [WordW-1:0] MaskLong  = 9'h1FF;
  localparam logic [WordW-1:0] MaskShort = 9'h0FF;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } sms_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BAUD_DIVIDER   = 3'd0,
    CFG_CLOCK_POLARITY = 3'd1,
    CFG_CLOCK_PHASE    = 3'd2,
    CFG_LSB_FIRST      = 3'd3,
    CFG_NINE_BIT       = 3'd4
  } sms_cfg_idx_e;

  typedef struct packed {
    logic [CntW-1:0] baud_divider;
    logic            clock_polarity;
    logic            clock_phase;
    logic            lsb_first;
    logic            nine_bit;
  } sms_cfg_t;

  typedef struct packed {
    logic             busy_res;
    logic             rx_overflow;
    logic             rx_complete;
    logic             data_empty;
    logic [WordW-1:0] rx_word;
    logic             mosi_level;
    logic             sck_level;
  } sms_result_t;

endpackage

// ----- hw/rtl/spi_master_shift_engine_core.sv -----
// Top level of the SPI master shift engine: stream ports, config and pipeline.
//
// Each input item on s_axis is one system clock tick of the serial engine. Its
// tuser carries the tick kind (plain, transmit write, receive read) and its
// tdata the transmit word and the sampled MISO level. Each item yields exactly
// one result item on m_axis with the pin levels, the receive register and the
// status flags as they stand after that tick.
// An item passes an input register, then the engine logic, then the result
// register; one item per cycle is taken in sustained flow while the receiver
// takes every result. The engine state advances only when an item moves from
// the input register into the result register.
// Reset clears all engine state and flags, the valid bits of the input and
// result registers, and the config registers to zero (SCK idles low). When
// the receiver stalls, the result register holds, the input register fills,
// and s_axis_tready drops until the receiver takes the waiting result.
// Config writes on cfg_we_i land at once; issue them only with no item
// in flight.
module spi_master_shift_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // tx_word[8:0], miso_level[9], zero fill
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sck_level[0], mosi_level[1], rx_word[10:2], data_empty[11],
  // rx_complete[12], rx_overflow[13], busy_res[14], zero fill
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [sms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sms_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import sms_pkg::*;

  sms_cfg_t cfg_q;

  logic             in_v_q;
  logic [1:0]       kind_q;
  logic [WordW-1:0] word_q;
  logic             miso_q;

  logic        out_v_q;
  sms_result_t res_q;
  sms_result_t res;
  logic [BitsW-1:0] bits_left;

  logic adv;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BAUD_DIVIDER:   cfg_q.baud_divider   <= cfg_wdata_i;
        CFG_CLOCK_POLARITY: cfg_q.clock_polarity <= cfg_wdata_i[0];
        CFG_CLOCK_PHASE:    cfg_q.clock_phase    <= cfg_wdata_i[0];
        CFG_LSB_FIRST:      cfg_q.lsb_first      <= cfg_wdata_i[0];
        CFG_NINE_BIT:       cfg_q.nine_bit       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q <= s_axis_tuser;
      word_q <= s_axis_tdata[WordW-1:0];
      miso_q <= s_axis_tdata[WordW];
    end
    if (adv) begin
      res_q <= res;
    end
  end

  sms_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (adv),
    .cfg_i        (cfg_q),
    .kind_i       (kind_q),
    .tx_word_i    (word_q),
    .miso_level_i (miso_q),
    .res_o        (res),
    .bits_left_o  (bits_left)
  );

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_left <= CharBitsLong)
    else $error("bit counter out of range");

  a_ovf_needs_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.rx_overflow |-> res_q.rx_complete)
    else $error("overflow without a waiting word");

  a_idle_sck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_q.busy_res |-> res_q.sck_level == cfg_q.clock_polarity)
    else $error("SCK not at idle level while idle");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_v_q)
    else $error("result lost after engine step");

endmodule

// ----- hw/rtl/sms_engine.sv -----
// Serial engine state and per-tick next-state logic.
module sms_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  sms_pkg::sms_cfg_t          cfg_i,
  input  logic [1:0]                 kind_i,
  input  logic [sms_pkg::WordW-1:0]  tx_word_i,
  input  logic                       miso_level_i,
  output sms_pkg::sms_result_t       res_o,
  output logic [sms_pkg::BitsW-1:0]  bits_left_o
);
  import sms_pkg::*;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] sw_q, sw_d;
  logic [BitsW-1:0] bits_q, bits_d;
  logic             half_q, half_d;
  logic             sck_q, sck_d;
  logic [WordW-1:0] txb_q, txb_d;
  logic             txf_q, txf_d;
  logic [WordW-1:0] rxb_q, rxb_d;
  logic             rxv_q, rxv_d;
  logic             ovf_q, ovf_d;
  logic             held_q, held_d;

  logic [WordW-1:0] mask;
  logic             bin;
  logic             front;

  always_comb begin
    cnt_d  = cnt_q;
    sw_d   = sw_q;
    bits_d = bits_q;
    half_d = half_q;
    sck_d  = sck_q;
    txb_d  = txb_q;
    txf_d  = txf_q;
    rxb_d  = rxb_q;
    rxv_d  = rxv_q;
    ovf_d  = ovf_q;
    held_d = held_q;
    mask   = cfg_i.nine_bit ? MaskLong : MaskShort;
    bin    = cfg_i.clock_phase ? miso_level_i : held_q;

    case (kind_i)
      KIND_WRITE: begin
        if (!txf_q) begin
          txb_d = tx_word_i;
          txf_d = 1'b1;
        end
      end
      KIND_READ: begin
        rxv_d = 1'b0;
        ovf_d = 1'b0;
      end
      default: ;
    endcase

    if (bits_q != '0) begin
      if (cnt_q >= cfg_i.baud_divider) begin
        cnt_d = '0;
        if (!half_q) begin
          sck_d = ~cfg_i.clock_polarity;
          if (!cfg_i.clock_phase) begin
            held_d = miso_level_i;
          end
          half_d = 1'b1;
        end else begin
          sck_d = cfg_i.clock_polarity;
          if (cfg_i.lsb_first) begin
            sw_d = ((sw_q & mask) >> 1) |
                   (cfg_i.nine_bit ? {bin, 8'b0} : {1'b0, bin, 7'b0});
          end else begin
            sw_d = {sw_q[WordW-2:0], bin} & mask;
          end
          bits_d = bits_q - 1'b1;
          if (bits_d == '0) begin
            ovf_d = ovf_d | rxv_d;
            rxb_d = sw_d & mask;
            rxv_d = 1'b1;
          end
          half_d = 1'b0;
        end
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    if (bits_d == '0) begin
      sck_d = cfg_i.clock_polarity;
      if (txf_d) begin
        sw_d   = txb_d & mask;
        txf_d  = 1'b0;
        bits_d = cfg_i.nine_bit ? CharBitsLong : CharBitsShort;
        half_d = 1'b0;
        cnt_d  = '0;
      end
    end

    if (cfg_i.lsb_first) begin
      front = sw_d[0];
    end else begin
      front = cfg_i.nine_bit ? sw_d[8] : sw_d[7];
    end

    res_o.sck_level   = sck_d;
    res_o.mosi_level  = (bits_d != '0) ? front : 1'b0;
    res_o.rx_word     = rxb_d;
    res_o.data_empty  = ~txf_d;
    res_o.rx_complete = rxv_d;
    res_o.rx_overflow = ovf_d;
    res_o.busy_res    = (bits_d != '0);
  end

  assign bits_left_o = bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sw_q   <= '0;
      bits_q <= '0;
      half_q <= 1'b0;
      sck_q  <= 1'b0;
      txb_q  <= '0;
      txf_q  <= 1'b0;
      rxb_q  <= '0;
      rxv_q  <= 1'b0;
      ovf_q  <= 1'b0;
      held_q <= 1'b0;
    end else if (step_i) begin
      cnt_q  <= cnt_d;
      sw_q   <= sw_d;
      bits_q <= bits_d;
      half_q <= half_d;
      sck_q  <= sck_d;
      txb_q  <= txb_d;
      txf_q  <= txf_d;
      rxb_q  <= rxb_d;
      rxv_q  <= rxv_d;
      ovf_q  <= ovf_d;
      held_q <= held_d;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking stream testbench for the SPI master shift engine core.
module tb;
  import sms_pkg::*;

  localparam logic [1:0]  KindSpare     = 2'd3;
  localparam int unsigned CfgRegCount   = 5;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit   = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  spi_master_shift_engine_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // engine model configuration
  logic [CntW-1:0]  c_baud;
  logic             c_cpol, c_cpha, c_lsb, c_nine;
  // engine model state
  logic [CntW-1:0]  m_div_count;
  logic [WordW-1:0] m_shift, m_tx_buf, m_rx_buf;
  logic [BitsW-1:0] m_bits_left;
  logic             m_second_edge, m_sck, m_tx_full, m_rx_valid, m_overrun, m_miso_hold;

  sms_result_t tick_snapshots[$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  bit          sink_hold     = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  task automatic clear_engine_model();
    c_baud        = '0;
    c_cpol        = 1'b0;
    c_cpha        = 1'b0;
    c_lsb         = 1'b0;
    c_nine        = 1'b0;
    m_div_count   = '0;
    m_shift       = '0;
    m_bits_left   = '0;
    m_second_edge = 1'b0;
    m_sck         = 1'b0;
    m_tx_buf      = '0;
    m_tx_full     = 1'b0;
    m_rx_buf      = '0;
    m_rx_valid    = 1'b0;
    m_overrun     = 1'b0;
    m_miso_hold   = 1'b0;
  endtask

  task automatic spi_engine_tick(input logic [1:0] kind, input logic [WordW-1:0] word,
                                 input logic miso, output sms_result_t snap);
    logic [BitsW-1:0] size;
    logic [WordW-1:0] mask;
    logic             bit_in;
    size = c_nine ? CharBitsLong : CharBitsShort;
    mask = c_nine ? MaskLong : MaskShort;
    if (kind == KIND_WRITE) begin
      if (!m_tx_full) begin
        m_tx_buf  = word;
        m_tx_full = 1'b1;
      end
    end else if (kind == KIND_READ) begin
      m_rx_valid = 1'b0;
      m_overrun  = 1'b0;
    end
    if (m_bits_left != '0) begin
      if (m_div_count >= c_baud) begin
        m_div_count = '0;
        if (!m_second_edge) begin
          m_sck = ~c_cpol;
          if (!c_cpha) m_miso_hold = miso;
          m_second_edge = 1'b1;
        end else begin
          m_sck  = c_cpol;
          bit_in = c_cpha ? miso : m_miso_hold;
          if (c_lsb) begin
            m_shift = ((m_shift & mask) >> 1) | (WordW'(bit_in) << (size - 1'b1));
          end else begin
            m_shift = {m_shift[WordW-2:0], bit_in} & mask;
          end
          m_bits_left = m_bits_left - 1'b1;
          if (m_bits_left == '0) begin
            if (m_rx_valid) m_overrun = 1'b1;
            m_rx_buf   = m_shift & mask;
            m_rx_valid = 1'b1;
          end
          m_second_edge = 1'b0;
        end
      end else begin
        m_div_count = m_div_count + 1'b1;
      end
    end
    if (m_bits_left == '0) begin
      m_sck = c_cpol;
      if (m_tx_full) begin
        m_shift       = m_tx_buf & mask;
        m_tx_full     = 1'b0;
        m_bits_left   = size;
        m_second_edge = 1'b0;
        m_div_count   = '0;
      end
    end
    snap.sck_level   = m_sck;
    snap.mosi_level  = (m_bits_left != '0) ? (c_lsb ? m_shift[0] : m_shift[size - 1'b1]) : 1'b0;
    snap.rx_word     = m_rx_buf;
    snap.data_empty  = ~m_tx_full;
    snap.rx_complete = m_rx_valid;
    snap.rx_overflow = m_overrun;
    snap.busy_res    = (m_bits_left != '0);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    sms_result_t want;
    sms_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = sms_result_t'(m_axis_tdata[$bits(sms_result_t)-1:0]);
      if (tick_snapshots.size() == 0) begin
        report_mismatch("unexpected result item", 0, 32'(m_axis_tdata));
      end else begin
        want = tick_snapshots.pop_front();
        if (got.sck_level != want.sck_level)
          report_mismatch("sck_level", 32'(want.sck_level), 32'(got.sck_level));
        if (got.mosi_level != want.mosi_level)
          report_mismatch("mosi_level", 32'(want.mosi_level), 32'(got.mosi_level));
        if (got.rx_word != want.rx_word)
          report_mismatch("rx_word", 32'(want.rx_word), 32'(got.rx_word));
        if (got.data_empty != want.data_empty)
          report_mismatch("data_empty", 32'(want.data_empty), 32'(got.data_empty));
        if (got.rx_complete != want.rx_complete)
          report_mismatch("rx_complete", 32'(want.rx_complete), 32'(got.rx_complete));
        if (got.rx_overflow != want.rx_overflow)
          report_mismatch("rx_overflow", 32'(want.rx_overflow), 32'(got.rx_overflow));
        if (got.busy_res != want.busy_res)
          report_mismatch("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [WordW-1:0] word,
                           input logic miso);
    sms_result_t snap;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, miso, word};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    spi_engine_tick(kind, word, miso, snap);
    tick_snapshots.push_back(snap);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tick_snapshots.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_BAUD_DIVIDER:   c_baud = data;
      CFG_CLOCK_POLARITY: c_cpol = data[0];
      CFG_CLOCK_PHASE:    c_cpha = data[0];
      CFG_LSB_FIRST:      c_lsb  = data[0];
      CFG_NINE_BIT:       c_nine = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic apply_config(input logic [CntW-1:0] baud, input logic cpol, input logic cpha,
                              input logic lsb, input logic nine);
    write_cfg(CFG_BAUD_DIVIDER, baud);
    write_cfg(CFG_CLOCK_POLARITY, {7'($urandom), cpol});
    write_cfg(CFG_CLOCK_PHASE, {7'($urandom), cpha});
    write_cfg(CFG_LSB_FIRST, {7'($urandom), lsb});
    write_cfg(CFG_NINE_BIT, {7'($urandom), nine});
  endtask

  task automatic drive_traffic(input int unsigned count, input int unsigned write_pct,
                               input int unsigned read_pct);
    logic [1:0]       kind;
    logic [WordW-1:0] word;
    int unsigned      roll;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      word = WordW'($urandom);
      if (roll < 10) begin
        kind = 2'($urandom);
      end else if (!m_tx_full && roll < 10 + write_pct) begin
        kind = KIND_WRITE;
      end else if (m_rx_valid && $urandom_range(99) < read_pct) begin
        kind = KIND_READ;
      end else begin
        kind = ($urandom_range(15) == 0) ? KindSpare : KIND_TICK;
      end
      send_item(kind, word, 1'($urandom));
    end
  endtask

  task automatic test_reset_state();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (4) send_item(KIND_TICK, '0, 1'b0);
    settle();
    for (int unsigned i = CfgRegCount; i < (1 << CfgIdxW); i++) begin
      write_cfg(CfgIdxW'(i), CfgDataW'($urandom));
    end
  endtask

  task automatic test_directed();
    apply_config('0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(KIND_WRITE, 9'h1FF, 1'b1);
    send_item(KIND_WRITE, 9'h000, 1'b0);
    send_item(KIND_WRITE, 9'h155, 1'b1);
    send_item(KindSpare, 9'h0AA, 1'b1);
    for (int unsigned n = 0; n < 12; n++) send_item(KIND_TICK, '0, n[0]);
    // read on the tick that completes the first character
    send_item(KIND_READ, 9'h1FF, 1'b1);
    repeat (5) send_item(KIND_TICK, 9'h100, 1'b1);
    send_item(KIND_READ, '0, 1'b0);
    settle();
  endtask

  task automatic test_slow_divider();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    apply_config(8'hFF, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    send_item(KIND_WRITE, WordW'($urandom), 1'($urandom));
    drive_traffic(300, 40, 20);
    settle();
    // lower the divider below the running count mid-character
    apply_config(8'd2, ~c_cpol, 1'($urandom), 1'($urandom), ~c_nine);
    drive_traffic(160, 40, 20);
    settle();
  endtask

  task automatic test_random_modes();
    logic [CntW-1:0] baud;
    logic [3:0]      mode;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
        default: begin src_idle_pct = 32; snk_stall_pct = 32; end
      endcase
      if (phase == 0) begin
        baud = '0;
        mode = 4'h0;
      end else if (phase == 1) begin
        baud = 8'd1;
        mode = 4'hF;
      end else begin
        baud = CntW'($urandom_range(5));
        mode = 4'($urandom);
      end
      apply_config(baud, mode[0], mode[1], mode[2], mode[3]);
      drive_traffic(100, 40, phase[0] ? 3 : 30);
      settle();
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    apply_config(8'd1, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    fork
      begin
        sink_hold = 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      drive_traffic(60, 40, 10);
    join
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_TICK;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_BAUD_DIVIDER;
    cfg_wdata_i   = '0;
    clear_engine_model();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_directed();
    test_slow_divider();
    test_random_modes();
    test_backpressure();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && tick_snapshots.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sms_pkg.sv
hw/rtl/sms_engine.sv
hw/rtl/spi_master_shift_engine_core.sv
tb/tb.sv
